// ----- rtl/box_position_to_rgb_color_macros.svh -----
// Assertion macros used by the RTL
`ifndef BOX_POSITION_TO_RGB_COLOR_MACROS_SVH
`define BOX_POSITION_TO_RGB_COLOR_MACROS_SVH

// Same-cycle implication, checked out of reset
`define BPRGB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked out of reset
`define BPRGB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/bprgb_pkg.sv -----
package bprgb_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned PosW     = 32;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned NormW    = FracBits + 1;
  localparam int unsigned DiffW    = PosW + 3;
  localparam int unsigned RemW     = PosW + 2;
  localparam int unsigned HueW     = NormW + 9;
  localparam int unsigned RemHueW  = FracBits + 6;
  localparam int unsigned QW       = RemHueW - 2;
  localparam int unsigned VW       = NormW + 2;

  // floor(v/5) as (v*Recip5) >> Val5Shift, exact for v < 5*One
  localparam int unsigned Val5Shift = FracBits + 5;
  localparam int unsigned Recip5W   = FracBits + 3;
  localparam longint unsigned Recip5 = ((64'd1 << Val5Shift) / 5) + 1;
  // floor(q/15) as (q*Recip15) >> T15Shift, exact for q < 15*One
  localparam int unsigned T15Shift  = FracBits + 8;
  localparam int unsigned Recip15W  = FracBits + 5;
  localparam longint unsigned Recip15 = ((64'd1 << T15Shift) / 15) + 1;

  localparam logic [NormW-1:0] One = {1'b1, {FracBits{1'b0}}};
  localparam logic [HueW-1:0] SectorSpan = HueW'(60) << FracBits;
  localparam logic [HueW-1:0] HueMax     = HueW'(350) << FracBits;

  // Insets in Q16.16 position units
  localparam logic signed [DiffW-1:0] XLoInset   = DiffW'(2 * 65536);
  localparam logic signed [DiffW-1:0] XSpanInset = DiffW'(4 * 65536);
  localparam logic signed [DiffW-1:0] YLoInset   = DiffW'(65536);
  localparam logic signed [DiffW-1:0] YSpanInset = DiffW'(3 * 32768);

  localparam logic signed [PosW-1:0] XMaxReset = PosW'(100 * 65536);
  localparam logic signed [PosW-1:0] YMaxReset = PosW'(100 * 65536);

  // Pipeline stage positions in the valid chain
  localparam int unsigned StP1      = FracBits + 2;
  localparam int unsigned StP2      = FracBits + 3;
  localparam int unsigned StP4      = FracBits + 5;
  localparam int unsigned NumStages = FracBits + 8;

  typedef enum logic [1:0] {
    RegXMin = 2'd0,
    RegXMax = 2'd1,
    RegYMin = 2'd2,
    RegYMax = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    Sec0 = 3'd0,
    Sec1 = 3'd1,
    Sec2 = 3'd2,
    Sec3 = 3'd3,
    Sec4 = 3'd4,
    Sec5 = 3'd5
  } sector_e;

endpackage

// ----- rtl/box_position_to_rgb_color.sv -----
// The pipeline has FracBits + 8 stages from input transaction to result.
// Throughput: one transaction per cycle; the 16-stage restoring divider for
// the normalised x and y positions is fully pipelined, one quotient bit a stage.
// A stalled output freezes the whole pipeline and stalls the input.
// Reset (asynchronous, active low) clears the valid bits and loads the box
// registers with 0 .. 100.0 on both axes.
`include "box_position_to_rgb_color_macros.svh"

module box_position_to_rgb_color import bprgb_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [PosW-1:0] pos_x_i,
  input  logic signed [PosW-1:0] pos_y_i,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [PosW-1:0]        cfg_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [ChanW-1:0]       red_o,
  output logic [ChanW-1:0]       green_o,
  output logic [ChanW-1:0]       blue_o
);

  logic signed [PosW-1:0] box_x_min_q, box_x_max_q, box_y_min_q, box_y_max_q;
  logic [NumStages-1:0] vld_q;
  logic adv;

  assign adv         = !(vld_q[NumStages-1] && out_stall_i);
  assign in_stall_o  = !adv;
  assign out_valid_o = vld_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_x_min_q <= '0;
      box_x_max_q <= XMaxReset;
      box_y_min_q <= '0;
      box_y_max_q <= YMaxReset;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        RegXMin: box_x_min_q <= cfg_data_i;
        RegXMax: box_x_max_q <= cfg_data_i;
        RegYMin: box_y_min_q <= cfg_data_i;
        RegYMax: box_y_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NumStages-2:0], in_valid_i};
    end
  end

  function automatic logic signed [DiffW-1:0] sx(input logic signed [PosW-1:0] a);
    return {{(DiffW-PosW){a[PosW-1]}}, a};
  endfunction

  // Stage A: numerator and span, lane 0 is x, lane 1 is y
  logic signed [DiffW-1:0] num_q [2];
  logic signed [DiffW-1:0] den_q [2];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num_q[0] <= sx(pos_x_i) - sx(box_x_min_q) - XLoInset;
      den_q[0] <= sx(box_x_max_q) - sx(box_x_min_q) - XSpanInset;
      num_q[1] <= sx(pos_y_i) - sx(box_y_min_q) - YLoInset;
      den_q[1] <= sx(box_y_max_q) - sx(box_y_min_q) - YSpanInset;
    end
  end

  // Stage B and divider stages
  logic [RemW-1:0]     rem_q  [2][FracBits+1];
  logic [RemW-1:0]     dvs_q  [2][FracBits+1];
  logic [FracBits-1:0] quo_q  [2][FracBits+1];
  logic                zero_q [2][FracBits+1];
  logic                full_q [2][FracBits+1];
  logic [RemW+1:0]     dsub   [2][FracBits];
  logic [RemW-1:0]     rem_d  [2][FracBits];
  logic                bit_d  [2][FracBits];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      for (int k = 0; k < FracBits; k++) begin
        dsub[l][k]  = {1'b0, rem_q[l][k], 1'b0} - {2'b00, dvs_q[l][k]};
        bit_d[l][k] = !dsub[l][k][RemW+1];
        rem_d[l][k] = bit_d[l][k] ? dsub[l][k][RemW-1:0] : {rem_q[l][k][RemW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        rem_q[l][0]  <= num_q[l][RemW-1:0];
        dvs_q[l][0]  <= den_q[l][RemW-1:0];
        quo_q[l][0]  <= '0;
        zero_q[l][0] <= den_q[l][DiffW-1] || (den_q[l] == '0) ||
                        num_q[l][DiffW-1] || (num_q[l] == '0);
        full_q[l][0] <= (num_q[l] >= den_q[l]);
        for (int k = 0; k < FracBits; k++) begin
          rem_q[l][k+1]  <= rem_d[l][k];
          dvs_q[l][k+1]  <= dvs_q[l][k];
          quo_q[l][k+1]  <= {quo_q[l][k][FracBits-2:0], bit_d[l][k]};
          zero_q[l][k+1] <= zero_q[l][k];
          full_q[l][k+1] <= full_q[l][k];
        end
      end
    end
  end

  logic [NormW-1:0] xn, yn;
  logic [VW-1:0]    vsum;

  always_comb begin
    xn = zero_q[0][FracBits] ? '0 :
         full_q[0][FracBits] ? One : {1'b0, quo_q[0][FracBits]};
    yn = zero_q[1][FracBits] ? '0 :
         full_q[1][FracBits] ? One : {1'b0, quo_q[1][FracBits]};
    vsum = {One, 2'b00} + VW'(yn);
  end

  // P1: hue, saturation, brightness product
  logic [HueW-1:0]          hue_q;
  logic [NormW-1:0]         sat1_q;
  logic [VW+Recip5W-1:0]    valp_q;
  // P2
  logic [NormW-1:0]         val2_q, sat2_q;
  sector_e                  sec2_q;
  logic [RemHueW-1:0]       rem2_q;
  // P3
  logic [2*NormW-1:0]       cp_q;
  logic [QW+Recip15W-1:0]   tp_q;
  logic [NormW-1:0]         val3_q;
  sector_e                  sec3_q;
  // P4
  logic [NormW-1:0]         c4_q, t4_q, m4_q;
  sector_e                  sec4_q;
  // P5
  logic [2*NormW-1:0]       xp5_q;
  logic [NormW-1:0]         c5_q, m5_q;
  sector_e                  sec5_q;
  // Output
  logic [ChanW-1:0]         red_q, green_q, blue_q;

  sector_e          sec_d;
  logic [HueW-1:0]  base_d;
  logic [NormW-1:0] c4_d, t4_d;

  always_comb begin
    sec_d  = Sec0;
    base_d = '0;
    if (hue_q >= SectorSpan) begin
      sec_d  = Sec1;
      base_d = SectorSpan;
    end
    if (hue_q >= HueW'(2 * SectorSpan)) begin
      sec_d  = Sec2;
      base_d = HueW'(2 * SectorSpan);
    end
    if (hue_q >= HueW'(3 * SectorSpan)) begin
      sec_d  = Sec3;
      base_d = HueW'(3 * SectorSpan);
    end
    if (hue_q >= HueW'(4 * SectorSpan)) begin
      sec_d  = Sec4;
      base_d = HueW'(4 * SectorSpan);
    end
    if (hue_q >= HueW'(5 * SectorSpan)) begin
      sec_d  = Sec5;
      base_d = HueW'(5 * SectorSpan);
    end
    c4_d = cp_q[FracBits +: NormW];
    t4_d = tp_q[T15Shift +: NormW];
    // falling ramp in odd sectors
    if (sec3_q == Sec1 || sec3_q == Sec3 || sec3_q == Sec5) begin
      t4_d = One - t4_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hue_q  <= HueW'(xn) * HueW'(350);
      sat1_q <= One - (yn >> 1);
      valp_q <= (VW+Recip5W)'(vsum) * (VW+Recip5W)'(Recip5);

      val2_q <= valp_q[Val5Shift +: NormW];
      sat2_q <= sat1_q;
      sec2_q <= sec_d;
      rem2_q <= RemHueW'(hue_q - base_d);

      cp_q   <= (2*NormW)'(val2_q) * (2*NormW)'(sat2_q);
      tp_q   <= (QW+Recip15W)'(rem2_q[RemHueW-1:2]) * (QW+Recip15W)'(Recip15);
      val3_q <= val2_q;
      sec3_q <= sec2_q;

      c4_q   <= c4_d;
      t4_q   <= t4_d;
      m4_q   <= val3_q - c4_d;
      sec4_q <= sec3_q;

      xp5_q  <= (2*NormW)'(c4_q) * (2*NormW)'(t4_q);
      c5_q   <= c4_q;
      m5_q   <= m4_q;
      sec5_q <= sec4_q;
    end
  end

  logic [NormW-1:0]   xv, pr, pg, pb;
  logic [NormW:0]     sr, sg, sb;
  logic [NormW+8:0]   kr, kg, kb;
  logic [ChanW-1:0]   r_d, g_d, b_d;

  function automatic logic [ChanW-1:0] to_chan(input logic [NormW+8:0] k);
    logic [NormW+8-FracBits:0] h;
    h = k[NormW+8:FracBits];
    return (h > (NormW+9-FracBits)'(255)) ? 8'hFF : h[ChanW-1:0];
  endfunction

  always_comb begin
    xv = xp5_q[FracBits +: NormW];
    case (sec5_q)
      Sec0: begin pr = c5_q; pg = xv;   pb = '0;   end
      Sec1: begin pr = xv;   pg = c5_q; pb = '0;   end
      Sec2: begin pr = '0;   pg = c5_q; pb = xv;   end
      Sec3: begin pr = '0;   pg = xv;   pb = c5_q; end
      Sec4: begin pr = xv;   pg = '0;   pb = c5_q; end
      default: begin pr = c5_q; pg = '0; pb = xv; end
    endcase
    sr = {1'b0, pr} + {1'b0, m5_q};
    sg = {1'b0, pg} + {1'b0, m5_q};
    sb = {1'b0, pb} + {1'b0, m5_q};
    // times 255
    kr = {sr, 8'h00} - (NormW+9)'(sr);
    kg = {sg, 8'h00} - (NormW+9)'(sg);
    kb = {sb, 8'h00} - (NormW+9)'(sb);
    r_d = to_chan(kr);
    g_d = to_chan(kg);
    b_d = to_chan(kb);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      red_q   <= r_d;
      green_q <= g_d;
      blue_q  <= b_d;
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

  `BPRGB_ASSERT_IMP(a_hue_range, vld_q[StP1], hue_q <= HueMax)
  `BPRGB_ASSERT_IMP(a_sat_range, vld_q[StP1], sat1_q <= One && sat1_q >= (One >> 1))
  `BPRGB_ASSERT_IMP(a_ramp_range, vld_q[StP4], t4_q <= One && m4_q <= One)
  `BPRGB_ASSERT_NXT(a_freeze, !adv, $stable(vld_q))

endmodule

// ----- bench/tb_box_position_to_rgb_color.sv -----
`timescale 1ns / 1ps

module tb_box_position_to_rgb_color import bprgb_pkg::*;;

  localparam longint Unit      = 65536;
  localparam longint FixOne    = 64'd1 << FracBits;
  localparam int     CycleLimit = 400000;
  localparam int     Drain     = 40;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } colour_t;

  typedef struct packed {
    logic [PosW-1:0] x;
    logic [PosW-1:0] y;
  } point_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic signed [PosW-1:0] pos_x_i;
  logic signed [PosW-1:0] pos_y_i;
  logic                   cfg_we_i;
  logic [1:0]             cfg_idx_i;
  logic [PosW-1:0]        cfg_data_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [ChanW-1:0]       red_o;
  logic [ChanW-1:0]       green_o;
  logic [ChanW-1:0]       blue_o;

  box_position_to_rgb_color DUT (.*);

  point_t  pending_points[$];
  colour_t expected_colours[$];
  longint  box_lo_x, box_hi_x, box_lo_y, box_hi_y;
  bit      hold_sender;
  int      gap_left, burst_left, stall_mode, stall_timer;
  int      errors;
  int      cycles;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint sext(logic [PosW-1:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint unsigned norm_pos(longint num, longint den);
    if (den <= 0 || num <= 0) return 0;
    if (num >= den) return FixOne;
    return (longint'(num) << FracBits) / den;
  endfunction

  function automatic logic [ChanW-1:0] scale_channel(longint unsigned p);
    longint unsigned r;
    r = (p * 255) >> FracBits;
    return (r > 255) ? 8'd255 : r[ChanW-1:0];
  endfunction

  function automatic colour_t hsv_colour(logic [PosW-1:0] px, logic [PosW-1:0] py);
    longint unsigned xn, yn, sat, bright, hue, rem, t, c, xc, m, r, g, b;
    sector_e sec;
    colour_t col;
    xn = norm_pos(sext(px) - box_lo_x - 2 * Unit, box_hi_x - box_lo_x - 4 * Unit);
    yn = norm_pos(sext(py) - box_lo_y - Unit, box_hi_y - box_lo_y - (3 * Unit) / 2);
    sat    = FixOne - (yn >> 1);
    bright = (4 * FixOne + yn) / 5;
    hue = xn * 350;
    sec = sector_e'(hue / (60 * FixOne));
    rem = hue - (hue / (60 * FixOne)) * (60 * FixOne);
    t   = rem / 60;
    if (sec[0]) t = FixOne - t;
    c  = (bright * sat) >> FracBits;
    xc = (c * t) >> FracBits;
    m  = bright - c;
    case (sec)
      Sec0:    begin r = c;  g = xc; b = 0;  end
      Sec1:    begin r = xc; g = c;  b = 0;  end
      Sec2:    begin r = 0;  g = c;  b = xc; end
      Sec3:    begin r = 0;  g = xc; b = c;  end
      Sec4:    begin r = xc; g = 0;  b = c;  end
      default: begin r = c;  g = 0;  b = xc; end
    endcase
    col.red   = scale_channel(r + m);
    col.green = scale_channel(g + m);
    col.blue  = scale_channel(b + m);
    return col;
  endfunction

  // Driver: bursts with random gaps, fed from the pending queue
  always @(posedge clk_i) begin
    logic   next_valid;
    point_t p;
    next_valid = in_valid_i;
    if (in_valid_i && !in_stall_o) begin
      expected_colours.push_back(hsv_colour(pos_x_i, pos_y_i));
      next_valid = 1'b0;
    end
    if (!next_valid && rst_ni) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_points.size() > 0 && !hold_sender) begin
        p = pending_points.pop_front();
        pos_x_i <= p.x;
        pos_y_i <= p.y;
        next_valid = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 20);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end
      end
    end
    in_valid_i <= next_valid;
  end

  // Monitor and receiver stall pattern
  always @(posedge clk_i) begin
    colour_t got, want;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
    if (out_valid_o && !out_stall_i) begin
      got = '{red_o, green_o, blue_o};
      if (expected_colours.size() == 0) begin
        $error("unexpected colour transaction r=%0d g=%0d b=%0d", red_o, green_o, blue_o);
        errors++;
      end else begin
        want = expected_colours.pop_front();
        if (got.red !== want.red) begin
          $error("red: expected %0d, got %0d", want.red, got.red);
          errors++;
        end
        if (got.green !== want.green) begin
          $error("green: expected %0d, got %0d", want.green, got.green);
          errors++;
        end
        if (got.blue !== want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, got.blue);
          errors++;
        end
      end
    end
    if (stall_timer == 0) begin
      stall_mode  = $urandom_range(0, 2);
      stall_timer = $urandom_range(50, 300);
    end else begin
      stall_timer--;
    end
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 9) < 7);
    endcase
  end

  task automatic write_box(reg_idx_e idx, longint value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[PosW-1:0];
    case (idx)
      RegXMin: box_lo_x = sext(value[PosW-1:0]);
      RegXMax: box_hi_x = sext(value[PosW-1:0]);
      RegYMin: box_lo_y = sext(value[PosW-1:0]);
      default: box_hi_y = sext(value[PosW-1:0]);
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_box(longint xlo, longint xhi, longint ylo, longint yhi);
    write_box(RegXMin, xlo);
    write_box(RegXMax, xhi);
    write_box(RegYMin, ylo);
    write_box(RegYMax, yhi);
  endtask

  task automatic add_point(longint x, longint y);
    point_t p;
    p.x = x[PosW-1:0];
    p.y = y[PosW-1:0];
    pending_points.push_back(p);
  endtask

  // Mostly near the box, a share anywhere in the 32-bit range
  function automatic longint near_box(longint lo, longint hi);
    logic [63:0] r;
    longint span;
    r = {$urandom, $urandom};
    if ($urandom_range(0, 4) == 0) return longint'(signed'(r[31:0]));
    span = hi - lo + 6 * Unit;
    if (span <= 0) span = 8 * Unit;
    return lo - 3 * Unit + longint'(r % span);
  endfunction

  task automatic wait_idle();
    while (pending_points.size() > 0 || expected_colours.size() > 0 || in_valid_i)
      @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
  endtask

  task automatic random_points(int n);
    repeat (n) add_point(near_box(box_lo_x, box_hi_x), near_box(box_lo_y, box_hi_y));
  endtask

  initial begin
    longint xl, xh, yl, yh;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    pos_x_i     = '0;
    pos_y_i     = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = RegXMin;
    cfg_data_i  = '0;
    out_stall_i = 1'b0;
    hold_sender = 1'b0;
    gap_left    = 0;
    burst_left  = 0;
    stall_mode  = 0;
    stall_timer = 0;
    errors      = 0;
    cycles      = 0;
    box_lo_x = 0; box_hi_x = 100 * Unit;
    box_lo_y = 0; box_hi_y = 100 * Unit;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset box: edges of the inset, clamping, each hue sector, full hue
    add_point(2 * Unit, Unit);
    add_point(98 * Unit, 99 * Unit);
    add_point(-64'sd2147483648, -64'sd2147483648);
    add_point(64'sd2147483647, 64'sd2147483647);
    add_point(0, 0);
    add_point(100 * Unit, 100 * Unit);
    for (int s = 0; s < 12; s++)
      add_point(2 * Unit + (96 * Unit * s) / 12 + 7, Unit + (98 * Unit * s) / 12 + 3);
    add_point(98 * Unit - 1, 50 * Unit);
    add_point(2 * Unit + 1, Unit + 1);
    wait_idle();

    // Span not positive on both axes
    set_box(10 * Unit, 14 * Unit, 5 * Unit, 6 * Unit + Unit / 2);
    add_point(12 * Unit, 6 * Unit);
    add_point(-64'sd2147483648, 64'sd2147483647);
    random_points(60);
    wait_idle();

    // Widest box; hold the sender mid-stream until the pipeline has drained
    set_box(-64'sd2147483648, 64'sd2147483647, -64'sd2147483648, 64'sd2147483647);
    random_points(250);
    while (pending_points.size() > 100) @(posedge clk_i);
    hold_sender = 1'b1;
    while (expected_colours.size() > 0 || in_valid_i) @(posedge clk_i);
    hold_sender = 1'b0;
    random_points(150);
    wait_idle();

    set_box(0, 100 * Unit, 0, 100 * Unit);
    random_points(300);
    wait_idle();

    for (int ph = 0; ph < 5; ph++) begin
      xl = longint'($urandom_range(0, 2000)) * Unit / 4 - 250 * Unit;
      xh = xl + longint'($urandom_range(0, 400)) * Unit / 8 + $urandom_range(0, 65535);
      yl = longint'($urandom_range(0, 2000)) * Unit / 4 - 250 * Unit;
      yh = yl + longint'($urandom_range(0, 400)) * Unit / 8 + $urandom_range(0, 65535);
      set_box(xl, xh, yl, yh);
      random_points(220);
      wait_idle();
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/bprgb_pkg.sv
rtl/box_position_to_rgb_color.sv
bench/tb_box_position_to_rgb_color.sv
